// File: sv/dsfr_pkg.sv
// ----------------------------------------------------------------------------
// dsfr_pkg - shared constants and types of the sound FIFO resampler
// Widths, register indexes, operation codes and the source rate table used
// by the channel interfaces and the resampler unit.
// ----------------------------------------------------------------------------
package dsfr_pkg;

  localparam int CPU_CLOCK_HZ     = 8000000;
  localparam int FIFO_DEPTH       = 4;
  localparam int MAX_OUT_PER_TICK = 64;

  localparam int WORD_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 3;

  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W  = $clog2(FIFO_DEPTH);
  localparam int OUTN_W = $clog2(MAX_OUT_PER_TICK + 1);

  // Source rate (16 bits) times cycles per line (11 bits).
  localparam int INC_W  = 27;
  // Holds the largest increment and the negative CPU clock after a sample.
  localparam int SACC_W = INC_W + 1;
  localparam int OACC_W = 32;
  localparam int ADD_W  = OACC_W + 1;

  localparam logic signed [ADD_W-1:0] ACC_MAX = ADD_W'(32'h7fff_ffff);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_SELECT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_OUTPUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_CHANNELS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_VOLUME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VOLUME    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_RATE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_LINE = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_out;
    logic [SAMPLE_W-1:0] right_out;
    logic                last;
  } result_t;

  function automatic logic [15:0] src_rate(input logic [1:0] sel);
    logic [15:0] r;
    unique case (sel)
      2'd0: r = 16'd6258;
      2'd1: r = 16'd12517;
      2'd2: r = 16'd25033;
      2'd3: r = 16'd50066;
      default: r = 16'd6258;
    endcase
    return r;
  endfunction

endpackage

// File: sv/dsfr_cmd_if.sv
// ----------------------------------------------------------------------------
// dsfr_cmd_if - command channel of the sound FIFO resampler
// Carries push and tick commands with valid/ready flow control.
// ----------------------------------------------------------------------------
interface dsfr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [dsfr_pkg::WORD_W-1:0] sample_word;

  modport source (output valid, output operation, output sample_word, input ready);
  modport sink   (input valid, input operation, input sample_word, output ready);
endinterface

// File: sv/dsfr_result_if.sv
// ----------------------------------------------------------------------------
// dsfr_result_if - result channel of the sound FIFO resampler
// Carries host-rate output pairs with valid/ready flow control.
// ----------------------------------------------------------------------------
interface dsfr_result_if;
  logic                          valid;
  logic                          ready;
  logic [dsfr_pkg::SAMPLE_W-1:0] left_out;
  logic [dsfr_pkg::SAMPLE_W-1:0] right_out;
  logic                          last;

  modport source (output valid, output left_out, output right_out, output last,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input last,
                  output ready);
endinterface

// File: sv/dma_sound_fifo_resampler_unit.sv
// ----------------------------------------------------------------------------
// dma_sound_fifo_resampler_unit - DMA sound FIFO with two-stage rate conversion
// Stereo words are pushed into a small FIFO; each scanline tick advances a
// source-rate accumulator, pops words, attenuates them and emits host-rate
// output pairs through a second accumulator.
// ----------------------------------------------------------------------------
// A push transfer leaves the sequencer in idle, so the unit stays ready.
// A tick transfer runs a sequencer around one shared saturating 33-bit
// accumulator adder, which performs every source and host accumulator step.
// A tick steps through the source and host accumulators for each source
// sample and may be held up by stalls on the result side; the command
// channel is not ready until the tick has finished. Results leave through
// an output register, so the final result of a tick (marked by last) is
// delivered as the tick completes. Up to 64 results are delivered per tick.
// ----------------------------------------------------------------------------
module dma_sound_fifo_resampler_unit (
  input  logic                             clk,
  input  logic                             rst,
  dsfr_cmd_if.sink                         cmd,
  dsfr_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [dsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsfr_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRCADD = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_OADD   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_SRCSUB = 3'd6;
  localparam logic [2:0] S_FLUSH  = 3'd7;

  localparam int ADD_W  = dsfr_pkg::ADD_W;
  localparam int SACC_W = dsfr_pkg::SACC_W;
  localparam int OACC_W = dsfr_pkg::OACC_W;

  localparam logic [dsfr_pkg::OUTN_W-1:0] MAX_OUT_CNT =
    dsfr_pkg::OUTN_W'(dsfr_pkg::MAX_OUT_PER_TICK);
  localparam logic [dsfr_pkg::CNT_W-1:0] DEPTH_CNT =
    dsfr_pkg::CNT_W'(dsfr_pkg::FIFO_DEPTH);

  // Configuration registers
  logic [1:0]  rate_select;
  logic        mono_mode;
  logic        signed_output;
  logic [1:0]  host_channels;
  logic [7:0]  left_volume;
  logic [7:0]  right_volume;
  logic [16:0] host_rate;
  logic [10:0] cycles_per_line;

  // Datapath state
  logic [2:0]                          state;
  logic [dsfr_pkg::WORD_W-1:0]         fifo_words [dsfr_pkg::FIFO_DEPTH];
  logic [dsfr_pkg::CNT_W-1:0]          fifo_count;
  logic [dsfr_pkg::WORD_W-1:0]         last_word;
  logic signed [SACC_W-1:0]            src_acc;
  logic signed [OACC_W-1:0]            out_acc;
  logic [dsfr_pkg::INC_W-1:0]          inc;
  logic                                phase;
  logic [dsfr_pkg::OUTN_W-1:0]         emit_cnt;
  logic                                hold_valid;
  dsfr_pkg::result_t                   hold_data;
  logic                                out_valid;
  dsfr_pkg::result_t                   out_data;

  logic [15:0]                         src;
  logic [dsfr_pkg::INC_W-1:0]          inc_prod;
  logic signed [ADD_W-1:0]             add_a;
  logic signed [ADD_W-1:0]             add_b;
  logic signed [ADD_W-1:0]             add_sum;
  logic signed [ADD_W-1:0]             add_res;
  logic                                cmd_fire;
  logic                                out_free;
  logic                                drain_go;
  logic                                can_emit;
  logic                                emit;
  logic                                flush_move;
  logic [7:0]                          vol_l;
  logic [7:0]                          vol_r;
  logic [7:0]                          pop_hi;
  logic [7:0]                          pop_lo;
  logic [dsfr_pkg::WORD_W-1:0]         pop_word;
  logic [7:0]                          cur_hi;
  logic [7:0]                          cur_lo;
  logic [7:0]                          mono_byte;
  logic signed [8:0]                   pair_sum;
  logic signed [8:0]                   pair_adj;
  logic signed [8:0]                   pair_avg;
  logic [8:0]                          pair_usum;
  logic [15:0]                         val_l;
  logic [15:0]                         val_r;
  dsfr_pkg::result_t                   new_res;

  // Signed byte times volume over 128, truncated toward zero.
  function automatic logic [7:0] scale_byte(input logic [7:0] b, input logic [6:0] v);
    logic signed [15:0] p;
    logic signed [15:0] q;
    p = 16'(signed'(b)) * 16'(signed'({1'b0, v}));
    q = (p < 0) ? p + 16'sd127 : p;
    return 8'(q >>> 7);
  endfunction

  function automatic logic [15:0] conv_byte(input logic [7:0] b, input logic sgn);
    return sgn ? {8'd0, b} : {2'd0, b, 6'd0};
  endfunction

  assign src      = dsfr_pkg::src_rate(rate_select);
  assign inc_prod = dsfr_pkg::INC_W'(src) * dsfr_pkg::INC_W'(cycles_per_line);
  assign cmd_fire = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free = !out_valid || result.ready;

  // Shared accumulator adder; every accumulator step goes through it.
  always_comb begin
    add_a = (state == S_SRCADD || state == S_SRCSUB) ?
            {{(ADD_W-SACC_W){src_acc[SACC_W-1]}}, src_acc} :
            {{(ADD_W-OACC_W){out_acc[OACC_W-1]}}, out_acc};
    case (state)
      S_SRCADD: add_b = ADD_W'(inc);
      S_OADD:   add_b = ADD_W'(host_rate);
      S_DRAIN:  add_b = ADD_W'(0) - ADD_W'(src);
      default:  add_b = ADD_W'(0) - ADD_W'(dsfr_pkg::CPU_CLOCK_HZ);
    endcase
    add_sum = add_a + add_b;
    add_res = (add_sum > dsfr_pkg::ACC_MAX) ? dsfr_pkg::ACC_MAX : add_sum;
  end

  // Attenuation and sign handling of the word at the FIFO head.
  always_comb begin
    vol_l = mono_mode ? 8'((left_volume >> 1) + (right_volume >> 1)) : left_volume;
    vol_r = mono_mode ? vol_l : right_volume;
    pop_hi = fifo_words[0][15:8];
    pop_lo = fifo_words[0][7:0];
    if (vol_l < 8'd128) begin
      pop_hi = scale_byte(fifo_words[0][15:8], vol_l[6:0]);
    end
    if (vol_r < 8'd128) begin
      pop_lo = scale_byte(fifo_words[0][7:0], vol_r[6:0]);
    end
    pop_word = {pop_hi, pop_lo};
    if (!signed_output) begin
      pop_word = pop_word ^ 16'h8080;
    end
  end

  // Output pair for the current source sample.
  always_comb begin
    cur_hi    = last_word[15:8];
    cur_lo    = last_word[7:0];
    mono_byte = phase ? cur_lo : cur_hi;
    pair_sum  = 9'(signed'(cur_hi)) + 9'(signed'(cur_lo));
    pair_adj  = (pair_sum < 0) ? pair_sum + 9'sd1 : pair_sum;
    pair_avg  = pair_adj >>> 1;
    pair_usum = 9'(cur_hi) + 9'(cur_lo);
    if (mono_mode) begin
      val_l = conv_byte(mono_byte, signed_output);
      val_r = val_l;
    end else if (host_channels == 2'd1) begin
      val_l = signed_output ? {8'd0, pair_avg[7:0]} : {2'd0, pair_usum, 5'd0};
      val_r = 16'd0;
    end else begin
      val_l = conv_byte(cur_hi, signed_output);
      val_r = conv_byte(cur_lo, signed_output);
    end
    new_res.left_out  = val_l;
    new_res.right_out = (host_channels == 2'd1) ? 16'd0 : val_r;
    new_res.last      = 1'b0;
  end

  assign drain_go   = !out_acc[OACC_W-1] && (emit_cnt < MAX_OUT_CNT);
  assign can_emit   = !hold_valid || out_free;
  assign emit       = (state == S_DRAIN) && drain_go && can_emit;
  assign flush_move = (state == S_FLUSH) && hold_valid && out_free;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_select     <= 2'd0;
      mono_mode       <= 1'b1;
      signed_output   <= 1'b1;
      host_channels   <= 2'd2;
      left_volume     <= 8'd128;
      right_volume    <= 8'd128;
      host_rate       <= 17'd44100;
      cycles_per_line <= 11'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsfr_pkg::REG_RATE_SELECT:     rate_select     <= cfg_data[1:0];
        dsfr_pkg::REG_MONO_MODE:       mono_mode       <= cfg_data[0];
        dsfr_pkg::REG_SIGNED_OUTPUT:   signed_output   <= cfg_data[0];
        dsfr_pkg::REG_HOST_CHANNELS:   host_channels   <= cfg_data[1:0];
        dsfr_pkg::REG_LEFT_VOLUME:     left_volume     <= cfg_data[7:0];
        dsfr_pkg::REG_RIGHT_VOLUME:    right_volume    <= cfg_data[7:0];
        dsfr_pkg::REG_HOST_RATE:       host_rate       <= cfg_data[16:0];
        dsfr_pkg::REG_CYCLES_PER_LINE: cycles_per_line <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fifo_count <= '0;
      last_word  <= '0;
      src_acc    <= '0;
      out_acc    <= '0;
      phase      <= 1'b0;
      emit_cnt   <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit && hold_valid || flush_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.operation == dsfr_pkg::OP_TICK) begin
              emit_cnt <= '0;
              state    <= S_SRCADD;
            end else if (fifo_count < DEPTH_CNT) begin
              fifo_count <= fifo_count + 1'b1;
            end
          end
        end
        S_SRCADD: begin
          src_acc <= add_res[SACC_W-1:0];
          state   <= S_CHECK;
        end
        S_CHECK: begin
          state <= src_acc[SACC_W-1] ? S_FLUSH : S_POP;
        end
        S_POP: begin
          if (fifo_count != '0) begin
            fifo_count <= fifo_count - 1'b1;
            last_word  <= pop_word;
          end
          phase <= 1'b0;
          state <= S_OADD;
        end
        S_OADD: begin
          out_acc <= add_res[OACC_W-1:0];
          state   <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drain_go) begin
            if (can_emit) begin
              out_acc    <= add_res[OACC_W-1:0];
              emit_cnt   <= emit_cnt + 1'b1;
              hold_valid <= 1'b1;
            end
          end else if (mono_mode && !phase) begin
            phase <= 1'b1;
            state <= S_OADD;
          end else begin
            state <= S_SRCSUB;
          end
        end
        S_SRCSUB: begin
          src_acc <= add_res[SACC_W-1:0];
          state   <= S_CHECK;
        end
        S_FLUSH: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers: FIFO storage, increment, held and outgoing results.
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.operation == dsfr_pkg::OP_PUSH && fifo_count < DEPTH_CNT) begin
      fifo_words[fifo_count[dsfr_pkg::IDX_W-1:0]] <= cmd.sample_word;
    end else if (state == S_POP && fifo_count != '0) begin
      for (int i = 0; i < dsfr_pkg::FIFO_DEPTH - 1; i++) begin
        fifo_words[i] <= fifo_words[i+1];
      end
    end
    if (cmd_fire) begin
      inc <= mono_mode ? (inc_prod >> 1) : inc_prod;
    end
    if (emit) begin
      hold_data <= new_res;
      if (hold_valid) begin
        out_data <= hold_data;
      end
    end
    if (flush_move) begin
      out_data <= {hold_data.left_out, hold_data.right_out, 1'b1};
    end
  end

  assign result.valid     = out_valid;
  assign result.left_out  = out_data.left_out;
  assign result.right_out = out_data.right_out;
  assign result.last      = out_data.last;

`ifndef SYNTHESIS
  // The FIFO never claims more words than it can hold.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= DEPTH_CNT)
    else $error("FIFO count exceeds depth");

  // A new command is only taken once the held result has been handed on.
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !hold_valid)
    else $error("held result still pending while ready for a command");

  // The per-tick result limit is respected.
  a_emit_limit: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= MAX_OUT_CNT)
    else $error("too many results in one tick");

  // An empty flush ends the tick at once.
  a_flush_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && !hold_valid) |=> state == S_IDLE)
    else $error("flush did not return to idle");

  // The last flag is only raised on the transfer that closes a tick.
  a_last_from_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid && out_data.last) |-> $past(state) == S_FLUSH)
    else $error("last result not produced by the flush step");
`endif

endmodule
